/* hdl/pect_pkg.sv */
`default_nettype none

package pect_pkg;

    localparam int ENTRIES_DEF  = 8;
    localparam int KEY_BITS_DEF = 32;
    localparam int PIN_BITS_DEF = 8;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 3;
    localparam int PINS_W   = 8;
    localparam int OCC_W    = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PIN    = 2'd0,
        OP_UNPIN  = 2'd1,
        OP_READ   = 2'd2,
        OP_MODIFY = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PIN_HIT   = 3'd0,
        ST_INSTALLED = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DONE      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_LAST,
        FSM_UPDATE,
        FSM_OUT
    } fsm_t;

    typedef struct packed {
        op_t              operation;
        logic [KEY_W-1:0] key;
        logic             end_of_batch;
    } in_beat_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [PINS_W-1:0]   pin_count;
        logic                evicted;
        logic [KEY_W-1:0]    evicted_key;
        logic                write_back;
        logic [OCC_W-1:0]    occupancy;
        logic                end_of_batch_out;
    } out_beat_t;

endpackage

`default_nettype wire

/* hdl/pinned_entry_cache_table.sv */
`default_nettype none

// Pinned-entry cache table: ENTRIES slots, each with a valid mark, a key, a pin count and a
// dirty mark, serving pin, unpin, read and modify requests one beat at a time with exactly
// one result beat per request. Every request walks all slots through a single shared
// key-match and victim-check stage fed by the slot memory's registered read port; s_ready
// stays low from acceptance until the result beat is taken and rises the cycle after, so
// a new request is accepted only once the last result beat is taken. Lookup picks the
// lowest matching valid slot; a missing pin installs into the lowest slot that is vacant
// or clean and unpinned, and reports full when none exists.
module pinned_entry_cache_table #(
    parameter int ENTRIES  = pect_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = pect_pkg::KEY_BITS_DEF,
    parameter int PIN_BITS = pect_pkg::PIN_BITS_DEF
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire pect_pkg::in_beat_t  s_beat,
    output logic                     m_valid,
    input  wire                      m_ready,
    output pect_pkg::out_beat_t      m_beat
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int WORD_W = KEY_BITS + PIN_BITS;
    localparam logic [PIN_BITS-1:0] PIN_MAX  = {PIN_BITS{1'b1}};
    localparam logic [PIN_BITS-1:0] PIN_ZERO = '0;
    localparam logic [PIN_BITS-1:0] PIN_ONE  = PIN_BITS'(1);

    pect_pkg::fsm_t state_reg, state_next;

    logic [WORD_W-1:0]   mem [ENTRIES];
    logic [WORD_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;
    logic [IDX_W-1:0]    wr_addr;
    logic [WORD_W-1:0]   wr_data;

    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  dirty_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    rd_cnt_reg;
    logic                cmp_vld_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;

    pect_pkg::op_t       op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                eob_reg;

    logic                hit_found_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [PIN_BITS-1:0] hit_pins_reg;
    logic                vic_found_reg;
    logic [IDX_W-1:0]    vic_idx_reg;
    logic                vic_was_valid_reg;
    logic [KEY_BITS-1:0] vic_key_reg;

    pect_pkg::out_beat_t out_reg;

    logic                accept;
    logic                do_scan;
    logic                do_update;
    logic [KEY_BITS-1:0] cmp_key;
    logic [PIN_BITS-1:0] cmp_pins;
    logic                cmp_hit;
    logic                cmp_vic;

    logic [PIN_BITS-1:0] pins_inc;
    logic [PIN_BITS-1:0] pins_dec;
    pect_pkg::out_beat_t out_next;
    logic                set_valid;
    logic                clr_dirty;
    logic                set_dirty;
    logic [IDX_W-1:0]    upd_idx;
    logic                count_inc;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pect_pkg::FSM_IDLE: begin
                if (s_valid) begin
                    state_next = pect_pkg::FSM_SCAN;
                end
            end
            pect_pkg::FSM_SCAN: begin
                if (rd_cnt_reg == CNT_W'(ENTRIES - 1)) begin
                    state_next = pect_pkg::FSM_LAST;
                end
            end
            pect_pkg::FSM_LAST: begin
                state_next = pect_pkg::FSM_UPDATE;
            end
            pect_pkg::FSM_UPDATE: begin
                state_next = pect_pkg::FSM_OUT;
            end
            pect_pkg::FSM_OUT: begin
                if (m_ready) begin
                    state_next = pect_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = pect_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        do_scan   = 1'b0;
        do_update = 1'b0;
        case (state_reg)
            pect_pkg::FSM_IDLE:   s_ready   = aresetn;
            pect_pkg::FSM_SCAN:   do_scan   = 1'b1;
            pect_pkg::FSM_LAST:   do_scan   = 1'b0;
            pect_pkg::FSM_UPDATE: do_update = 1'b1;
            pect_pkg::FSM_OUT:    m_valid   = aresetn;
            default:              s_ready   = 1'b0;
        endcase
    end

    assign accept  = s_valid && s_ready;
    assign rd_addr = rd_cnt_reg[IDX_W-1:0];
    assign m_beat  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pect_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign cmp_key  = rd_data_reg[WORD_W-1:PIN_BITS];
    assign cmp_pins = rd_data_reg[PIN_BITS-1:0];
    assign cmp_hit  = valid_reg[cmp_idx_reg] && (cmp_key == key_reg);
    assign cmp_vic  = !valid_reg[cmp_idx_reg]
                      || (!dirty_reg[cmp_idx_reg] && (cmp_pins == PIN_ZERO));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_cnt_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_found_reg <= 1'b0;
            vic_found_reg <= 1'b0;
        end else begin
            cmp_vld_reg <= do_scan;
            if (accept) begin
                rd_cnt_reg    <= '0;
                hit_found_reg <= 1'b0;
                vic_found_reg <= 1'b0;
            end else begin
                if (do_scan) begin
                    rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                end
                if (cmp_vld_reg && cmp_hit && !hit_found_reg) begin
                    hit_found_reg <= 1'b1;
                end
                if (cmp_vld_reg && cmp_vic && !vic_found_reg) begin
                    vic_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_beat.operation;
            key_reg <= KEY_BITS'(s_beat.key);
            eob_reg <= s_beat.end_of_batch;
        end
        if (do_scan) begin
            cmp_idx_reg <= rd_addr;
        end
        if (cmp_vld_reg && cmp_hit && !hit_found_reg) begin
            hit_idx_reg  <= cmp_idx_reg;
            hit_pins_reg <= cmp_pins;
        end
        if (cmp_vld_reg && cmp_vic && !vic_found_reg) begin
            vic_idx_reg       <= cmp_idx_reg;
            vic_was_valid_reg <= valid_reg[cmp_idx_reg];
            vic_key_reg       <= cmp_key;
        end
        if (do_update) begin
            out_reg <= out_next;
        end
    end

    assign pins_inc = (hit_pins_reg == PIN_MAX) ? hit_pins_reg : hit_pins_reg + PIN_ONE;
    assign pins_dec = (hit_pins_reg == PIN_ZERO) ? hit_pins_reg : hit_pins_reg - PIN_ONE;

    always_comb begin
        out_next                  = '0;
        out_next.status           = pect_pkg::ST_NOT_FOUND;
        out_next.end_of_batch_out = eob_reg;
        mem_we    = 1'b0;
        wr_addr   = hit_idx_reg;
        wr_data   = {key_reg, hit_pins_reg};
        set_valid = 1'b0;
        clr_dirty = 1'b0;
        set_dirty = 1'b0;
        upd_idx   = hit_idx_reg;
        count_inc = 1'b0;
        if (op_reg == pect_pkg::OP_PIN) begin
            if (hit_found_reg) begin
                mem_we             = do_update;
                wr_data            = {key_reg, pins_inc};
                out_next.status    = pect_pkg::ST_PIN_HIT;
                out_next.slot      = pect_pkg::SLOT_W'(hit_idx_reg);
                out_next.pin_count = pect_pkg::PINS_W'(pins_inc);
            end else if (vic_found_reg) begin
                mem_we               = do_update;
                wr_addr              = vic_idx_reg;
                wr_data              = {key_reg, PIN_ONE};
                upd_idx              = vic_idx_reg;
                set_valid            = do_update;
                clr_dirty            = do_update;
                count_inc            = do_update && !vic_was_valid_reg;
                out_next.status      = pect_pkg::ST_INSTALLED;
                out_next.slot        = pect_pkg::SLOT_W'(vic_idx_reg);
                out_next.pin_count   = pect_pkg::PINS_W'(PIN_ONE);
                out_next.evicted     = vic_was_valid_reg;
                out_next.evicted_key = vic_was_valid_reg
                                       ? pect_pkg::KEY_W'(vic_key_reg) : '0;
            end else begin
                out_next.status = pect_pkg::ST_FULL;
            end
        end else if (hit_found_reg) begin
            out_next.status    = pect_pkg::ST_DONE;
            out_next.slot      = pect_pkg::SLOT_W'(hit_idx_reg);
            out_next.pin_count = pect_pkg::PINS_W'(hit_pins_reg);
            if (op_reg == pect_pkg::OP_UNPIN) begin
                mem_we              = do_update;
                wr_data             = {key_reg, pins_dec};
                clr_dirty           = do_update;
                out_next.pin_count  = pect_pkg::PINS_W'(pins_dec);
                out_next.write_back = dirty_reg[hit_idx_reg];
            end else if (op_reg == pect_pkg::OP_MODIFY) begin
                set_dirty = do_update;
            end
        end
        out_next.occupancy = pect_pkg::OCC_W'(count_reg + CNT_W'(!vic_was_valid_reg
                                                                 && out_next.status
                                                                 == pect_pkg::ST_INSTALLED));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            dirty_reg <= '0;
            count_reg <= '0;
        end else begin
            if (set_valid) begin
                valid_reg[upd_idx] <= 1'b1;
            end
            if (clr_dirty) begin
                dirty_reg[upd_idx] <= 1'b0;
            end
            if (set_dirty) begin
                dirty_reg[upd_idx] <= 1'b1;
            end
            if (count_inc) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/pect_checker.sv */
`default_nettype none

module pect_checker #(
    parameter int ENTRIES = pect_pkg::ENTRIES_DEF
) (
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      s_valid,
    input wire                      s_ready,
    input wire pect_pkg::in_beat_t  s_beat,
    input wire                      m_valid,
    input wire                      m_ready,
    input wire pect_pkg::out_beat_t m_beat
);

    localparam int OCC_MAX = (ENTRIES > 15) ? 15 : ENTRIES;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_beat))
        else $error("result beat changed while stalled");

    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("request accepted while another is in flight");

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_beat.status == pect_pkg::ST_FULL
                    || m_beat.status == pect_pkg::ST_NOT_FOUND)
        |-> m_beat.slot == '0 && m_beat.pin_count == '0 && !m_beat.evicted
            && !m_beat.write_back)
        else $error("missing-entry result carries slot data");

    a_install: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_beat.status == pect_pkg::ST_INSTALLED
        |-> m_beat.pin_count == 8'd1 && m_beat.occupancy != 4'd0
            && m_beat.occupancy <= 4'(OCC_MAX))
        else $error("install result inconsistent");

endmodule

bind pinned_entry_cache_table pect_checker #(.ENTRIES(ENTRIES)) u_pect_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_beat  (s_beat),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_beat  (m_beat)
);

`default_nettype wire

/* dv/tb_top.sv */
module tb_top;

    localparam int ENTRIES      = pect_pkg::ENTRIES_DEF;
    localparam int PIN_MAX      = (1 << pect_pkg::PIN_BITS_DEF) - 1;
    localparam int KEY_W        = pect_pkg::KEY_W;
    localparam int POOL         = 12;
    localparam int WATCHDOG     = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        pect_pkg::in_beat_t  req;
        bit                  typed;
        pect_pkg::out_beat_t rsp;
    } dir_row_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    pect_pkg::in_beat_t  s_beat  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    pect_pkg::out_beat_t m_beat;

    int send_idle_pct = 9;
    int recv_idle_pct = 64;
    int idle_cycles   = 0;
    int mismatches    = 0;
    int req_beats     = 0;
    int rsp_beats     = 0;
    int n_installs    = 0;
    int n_evictions   = 0;
    int n_full        = 0;
    int n_write_backs = 0;

    logic             cache_valid [ENTRIES];
    logic [KEY_W-1:0] cache_key   [ENTRIES];
    int               cache_pins  [ENTRIES];
    logic             cache_dirty [ENTRIES];
    int               cache_fill;

    pect_pkg::out_beat_t cache_rsp_q [$];
    dir_row_t            dir_rows    [$];
    logic [KEY_W-1:0]    key_pool    [POOL];

    pinned_entry_cache_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_beat  (s_beat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_beat  (m_beat)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic pect_pkg::in_beat_t req_of(input pect_pkg::op_t op,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic eob);
        pect_pkg::in_beat_t b;
        b.operation    = op;
        b.key          = key;
        b.end_of_batch = eob;
        return b;
    endfunction

    function automatic pect_pkg::out_beat_t rsp_of(input pect_pkg::status_t st,
                                                   input int slot, input int pins,
                                                   input int ev, input logic [KEY_W-1:0] evk,
                                                   input int wb, input int occ,
                                                   input logic eob);
        pect_pkg::out_beat_t r;
        r.status           = st;
        r.slot             = slot[pect_pkg::SLOT_W-1:0];
        r.pin_count        = pins[pect_pkg::PINS_W-1:0];
        r.evicted          = ev[0];
        r.evicted_key      = evk;
        r.write_back       = wb[0];
        r.occupancy        = occ[pect_pkg::OCC_W-1:0];
        r.end_of_batch_out = eob;
        return r;
    endfunction

    function automatic dir_row_t typed_row(input pect_pkg::op_t op,
                                           input logic [KEY_W-1:0] key,
                                           input logic eob, input pect_pkg::status_t st,
                                           input int slot, input int pins, input int ev,
                                           input logic [KEY_W-1:0] evk, input int wb,
                                           input int occ);
        dir_row_t r;
        r.req   = req_of(op, key, eob);
        r.typed = 1'b1;
        r.rsp   = rsp_of(st, slot, pins, ev, evk, wb, occ, eob);
        return r;
    endfunction

    function automatic dir_row_t pred_row(input pect_pkg::op_t op,
                                          input logic [KEY_W-1:0] key, input logic eob);
        dir_row_t r;
        r.req   = req_of(op, key, eob);
        r.typed = 1'b0;
        r.rsp   = '0;
        return r;
    endfunction

    function automatic string beat_str(input pect_pkg::out_beat_t b);
        return $sformatf("st=%0d slot=%0d pins=%0d ev=%0d evk=%h wb=%0d occ=%0d eob=%0d",
                         b.status, b.slot, b.pin_count, b.evicted, b.evicted_key,
                         b.write_back, b.occupancy, b.end_of_batch_out);
    endfunction

    task automatic predict_cache(input pect_pkg::in_beat_t req,
                                 output pect_pkg::out_beat_t rsp);
        int i;
        int hit;
        int vic;
        hit = -1;
        vic = -1;
        rsp = '0;
        rsp.status           = pect_pkg::ST_NOT_FOUND;
        rsp.end_of_batch_out = req.end_of_batch;
        for (i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && cache_valid[i] && cache_key[i] == req.key)
                hit = i;
            if (vic < 0 && (!cache_valid[i] || (!cache_dirty[i] && cache_pins[i] == 0)))
                vic = i;
        end
        if (req.operation == pect_pkg::OP_PIN) begin
            if (hit >= 0) begin
                if (cache_pins[hit] < PIN_MAX)
                    cache_pins[hit]++;
                rsp.status = pect_pkg::ST_PIN_HIT;
            end else if (vic < 0) begin
                rsp.status = pect_pkg::ST_FULL;
            end else begin
                if (cache_valid[vic]) begin
                    rsp.evicted     = 1'b1;
                    rsp.evicted_key = cache_key[vic];
                end else begin
                    cache_fill++;
                end
                cache_valid[vic] = 1'b1;
                cache_key[vic]   = req.key;
                cache_pins[vic]  = 1;
                cache_dirty[vic] = 1'b0;
                rsp.status       = pect_pkg::ST_INSTALLED;
                hit              = vic;
            end
        end else if (hit >= 0) begin
            if (req.operation == pect_pkg::OP_UNPIN) begin
                if (cache_pins[hit] > 0)
                    cache_pins[hit]--;
                if (cache_dirty[hit]) begin
                    rsp.write_back   = 1'b1;
                    cache_dirty[hit] = 1'b0;
                end
            end else if (req.operation == pect_pkg::OP_MODIFY) begin
                cache_dirty[hit] = 1'b1;
            end
            rsp.status = pect_pkg::ST_DONE;
        end
        if (hit >= 0) begin
            rsp.slot      = hit[pect_pkg::SLOT_W-1:0];
            rsp.pin_count = cache_pins[hit][pect_pkg::PINS_W-1:0];
        end
        rsp.occupancy = cache_fill[pect_pkg::OCC_W-1:0];
    endtask

    task automatic send_beat(input pect_pkg::in_beat_t b, input bit typed,
                             input pect_pkg::out_beat_t want);
        pect_pkg::out_beat_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_beat  <= b;
        do @(posedge aclk); while (!s_ready);
        predict_cache(b, pred);
        n_installs    += (pred.status == pect_pkg::ST_INSTALLED);
        n_evictions   += pred.evicted;
        n_full        += (pred.status == pect_pkg::ST_FULL);
        n_write_backs += pred.write_back;
        req_beats++;
        cache_rsp_q.push_back(typed ? want : pred);
        @(negedge aclk);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (cache_rsp_q.size() != 0)
            @(negedge aclk);
    endtask

    function automatic int pick_cached_slot();
        int slots [$];
        int i;
        for (i = 0; i < ENTRIES; i++)
            if (cache_valid[i])
                slots.push_back(i);
        if (slots.size() == 0)
            return -1;
        return slots[$urandom_range(slots.size() - 1)];
    endfunction

    function automatic logic [KEY_W-1:0] pool_key();
        return key_pool[$urandom_range(POOL - 1)];
    endfunction

    function automatic logic [KEY_W-1:0] likely_cached_key();
        int s;
        s = pick_cached_slot();
        if (s >= 0 && $urandom_range(4) != 0)
            return cache_key[s];
        return pool_key();
    endfunction

    task automatic random_traffic(input int budget, input bit with_hammer);
        int sent;
        int n;
        int j;
        int kind;
        int s;
        logic [KEY_W-1:0] key;
        sent = 0;
        if (with_hammer) begin
            s   = pick_cached_slot();
            key = (s >= 0) ? cache_key[s] : key_pool[0];
            repeat (PIN_MAX + 4) begin
                send_beat(req_of(pect_pkg::OP_PIN, key, 1'($urandom_range(1))), 1'b0, '0);
                sent++;
            end
            repeat (PIN_MAX + 6) begin
                send_beat(req_of(pect_pkg::OP_UNPIN, key, 1'($urandom_range(1))), 1'b0, '0);
                sent++;
            end
        end
        while (sent < budget) begin
            kind = $urandom_range(99);
            n    = $urandom_range(5, 1);
            if (kind < 35) begin
                for (j = 0; j < n; j++) begin
                    key = ($urandom_range(9) == 0) ? $urandom : pool_key();
                    send_beat(req_of(pect_pkg::OP_PIN, key, j == n - 1), 1'b0, '0);
                end
                sent += n;
            end else if (kind < 60) begin
                for (j = 0; j < n; j++)
                    send_beat(req_of(pect_pkg::OP_UNPIN, likely_cached_key(), j == n - 1),
                              1'b0, '0);
                sent += n;
            end else if (kind < 80) begin
                send_beat(req_of($urandom_range(1) ? pect_pkg::OP_READ : pect_pkg::OP_MODIFY,
                                 likely_cached_key(), 1'($urandom_range(1))), 1'b0, '0);
                sent++;
            end else if (kind < 92) begin
                send_beat(req_of(pect_pkg::op_t'($urandom_range(3)), $urandom,
                                 1'($urandom_range(1))), 1'b0, '0);
                sent++;
            end else begin
                s = pick_cached_slot();
                if (s >= 0) begin
                    key = cache_key[s];
                    n   = (cache_pins[s] < 15) ? cache_pins[s] + 1 : 16;
                    for (j = 0; j < n; j++)
                        send_beat(req_of(pect_pkg::OP_UNPIN, key, j == n - 1), 1'b0, '0);
                    sent += n;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        pect_pkg::out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            rsp_beats++;
            if (cache_rsp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result beat: %s", beat_str(m_beat));
            end else begin
                want = cache_rsp_q.pop_front();
                if (m_beat.status !== want.status || m_beat.slot !== want.slot ||
                    m_beat.pin_count !== want.pin_count || m_beat.evicted !== want.evicted ||
                    m_beat.evicted_key !== want.evicted_key ||
                    m_beat.write_back !== want.write_back ||
                    m_beat.occupancy !== want.occupancy ||
                    m_beat.end_of_batch_out !== want.end_of_batch_out) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("mismatch at result %0d", rsp_beats);
                        $display("  expected %s", beat_str(want));
                        $display("  actual   %s", beat_str(m_beat));
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            cache_valid[i] = 1'b0;
            cache_key[i]   = '0;
            cache_pins[i]  = 0;
            cache_dirty[i] = 1'b0;
        end
        cache_fill  = 0;
        key_pool[0] = '0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (i = 2; i < POOL; i++)
            key_pool[i] = $urandom;

        dir_rows.push_back(typed_row(pect_pkg::OP_READ, 32'h0, 1'b1, pect_pkg::ST_NOT_FOUND,
                                     0, 0, 0, 0, 0, 0));
        dir_rows.push_back(typed_row(pect_pkg::OP_UNPIN, 32'hFFFF_FFFF, 1'b0,
                                     pect_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(typed_row(pect_pkg::OP_MODIFY, 32'h0, 1'b1,
                                     pect_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(typed_row(pect_pkg::OP_PIN, 32'h0, 1'b0, pect_pkg::ST_INSTALLED,
                                     0, 1, 0, 0, 0, 1));
        dir_rows.push_back(typed_row(pect_pkg::OP_PIN, 32'hFFFF_FFFF, 1'b1,
                                     pect_pkg::ST_INSTALLED, 1, 1, 0, 0, 0, 2));
        dir_rows.push_back(typed_row(pect_pkg::OP_PIN, 32'h0, 1'b1, pect_pkg::ST_PIN_HIT,
                                     0, 2, 0, 0, 0, 2));
        dir_rows.push_back(typed_row(pect_pkg::OP_MODIFY, 32'hFFFF_FFFF, 1'b0,
                                     pect_pkg::ST_DONE, 1, 1, 0, 0, 0, 2));
        dir_rows.push_back(typed_row(pect_pkg::OP_UNPIN, 32'hFFFF_FFFF, 1'b1,
                                     pect_pkg::ST_DONE, 1, 0, 0, 0, 1, 2));
        dir_rows.push_back(typed_row(pect_pkg::OP_UNPIN, 32'hFFFF_FFFF, 1'b0,
                                     pect_pkg::ST_DONE, 1, 0, 0, 0, 0, 2));
        dir_rows.push_back(typed_row(pect_pkg::OP_PIN, 32'h5A5A_0001, 1'b1,
                                     pect_pkg::ST_INSTALLED, 1, 1, 1, 32'hFFFF_FFFF, 0, 2));
        dir_rows.push_back(pred_row(pect_pkg::OP_READ, 32'h5A5A_0001, 1'b0));
        for (i = 0; i < 6; i++)
            dir_rows.push_back(pred_row(pect_pkg::OP_PIN, 32'h0000_0010 + i, i == 5));
        dir_rows.push_back(typed_row(pect_pkg::OP_PIN, 32'hC0DE_0007, 1'b1,
                                     pect_pkg::ST_FULL, 0, 0, 0, 0, 0, 8));
        dir_rows.push_back(pred_row(pect_pkg::OP_UNPIN, 32'h5A5A_0001, 1'b0));
        dir_rows.push_back(pred_row(pect_pkg::OP_MODIFY, 32'h5A5A_0001, 1'b1));
        dir_rows.push_back(typed_row(pect_pkg::OP_PIN, 32'hC0DE_0007, 1'b0,
                                     pect_pkg::ST_FULL, 0, 0, 0, 0, 0, 8));
        dir_rows.push_back(pred_row(pect_pkg::OP_UNPIN, 32'h5A5A_0001, 1'b0));
        dir_rows.push_back(typed_row(pect_pkg::OP_PIN, 32'hC0DE_0007, 1'b1,
                                     pect_pkg::ST_INSTALLED, 1, 1, 1, 32'h5A5A_0001, 0, 8));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
        random_traffic(300, 1'b0);

        hold_until_drained();
        send_idle_pct = 64;
        recv_idle_pct = 9;
        random_traffic(300, 1'b0);

        hold_until_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(500, 1'b1);
        s_valid <= 1'b0;

        while (cache_rsp_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d request beats (%0d directed), checked %0d result beats",
                 req_beats, dir_rows.size(), rsp_beats);
        $display("installs %0d, evictions %0d, table full %0d, write-backs %0d, mismatches %0d",
                 n_installs, n_evictions, n_full, n_write_backs, mismatches);
        if (mismatches == 0 && cache_rsp_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
